### design/cths_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cths_pkg: shared definitions for the crypt table string hash
// Table geometry, generator constants, seed start values and the
// interface struct between the table fill sequencer and the top level.
// ----------------------------------------------------------------------------
package cths_pkg;

	localparam int TBL_DEPTH = 1280;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);
	localparam int WORD_W    = 32;
	localparam int GEN_W     = 22;
	localparam int ACC_W     = 29;   // holds gen * 125 + 3 for gen below the modulus
	localparam int QUO_SH    = 23;   // 3 * modulus is 2**23 + 1
	localparam int QUO_W     = ACC_W + 1 - QUO_SH;
	localparam int ROW_W     = 3;
	localparam int COL_W     = 8;

	localparam logic [GEN_W-1:0]  GEN_START = 22'h100001;
	localparam logic [GEN_W-1:0]  GEN_MOD   = 22'h2AAAAB;
	localparam logic [ACC_W-1:0]  GEN_MULT  = 29'd125;
	localparam logic [ACC_W-1:0]  GEN_ADD   = 29'd3;
	localparam logic [ROW_W-1:0]  ROW_LAST  = 3'd4;
	localparam logic [COL_W-1:0]  COL_LAST  = 8'hFF;

	localparam logic [WORD_W-1:0] SEED1_INIT = 32'h7FED7FED;
	localparam logic [WORD_W-1:0] SEED2_INIT = 32'hEEEEEEEE;
	localparam logic [WORD_W-1:0] SEED2_ADD  = 32'd3;

	typedef struct packed {
		logic                we;
		logic [TBL_AW-1:0]   addr;
		logic [WORD_W-1:0]   data;
		logic                done;
	} cths_fill_t;

	// fold ASCII lower case letters to upper case, leave every other byte alone
	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

endpackage

### design/cths_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cths_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module cths_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 1280
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/cths_fill.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cths_fill: crypt table fill sequencer
// Runs the generator (gen * 125 + 3) mod 0x2AAAAB twice per word and writes
// the table column by column after reset. The quotient is estimated as
// (3 * acc) >> 23, one subtract follows, then an add-back if it overshot;
// each generator step passes through the ST_MUL, ST_RED and ST_NEXT states.
// ----------------------------------------------------------------------------
module cths_fill (
	input  logic                clk,
	input  logic                arst_n,
	output cths_pkg::cths_fill_t fill
);
	import cths_pkg::*;

	localparam logic [1:0] ST_MUL  = 2'd0;
	localparam logic [1:0] ST_RED  = 2'd1;
	localparam logic [1:0] ST_NEXT = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]       state_q;
	logic [GEN_W-1:0] gen_q;
	logic [ACC_W-1:0] acc_q;
	logic             half_q;
	logic [15:0]      hi_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [ACC_W:0]   acc_x3;
	logic [QUO_W-1:0] quo_est;
	logic [GEN_W-1:0] gen_nx;

	// estimate is the true quotient or one above it
	assign acc_x3  = {1'b0, acc_q} + {acc_q, 1'b0};
	assign quo_est = acc_x3[ACC_W:QUO_SH];

	// add the modulus back when the estimate overshot
	assign gen_nx = acc_q[ACC_W-1] ? (acc_q[GEN_W-1:0] + GEN_MOD) : acc_q[GEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MUL;
			gen_q   <= GEN_START;
			half_q  <= 1'b0;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			case (state_q)
				ST_MUL: begin
					state_q <= ST_RED;
				end
				ST_RED: begin
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					gen_q   <= gen_nx;
					half_q  <= ~half_q;
					state_q <= ST_MUL;
					if (half_q) begin
						if (row_q == ROW_LAST) begin
							row_q <= '0;
							if (col_q == COL_LAST) begin
								state_q <= ST_DONE;
							end else begin
								col_q <= col_q + 8'd1;
							end
						end else begin
							row_q <= row_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_DONE;
				end
			endcase
		end
	end

	// datapath of the generator, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			acc_q <= ACC_W'(gen_q) * GEN_MULT + GEN_ADD;
		end else if (state_q == ST_RED) begin
			acc_q <= acc_q - ACC_W'(quo_est) * ACC_W'(GEN_MOD);
		end
		if (state_q == ST_NEXT && !half_q) begin
			hi_q <= gen_nx[15:0];
		end
	end

	assign fill.we   = (state_q == ST_NEXT) && half_q;
	assign fill.addr = {row_q, col_q};
	assign fill.data = {hi_q, gen_nx[15:0]};
	assign fill.done = (state_q == ST_DONE);

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fill.done |=> fill.done)
		else $error("fill done dropped");

	a_red_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEXT) |-> (gen_nx < GEN_MOD))
		else $error("generator value not reduced below modulus");

	a_no_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		fill.done |-> !fill.we)
		else $error("table write after fill completed");

endmodule

### design/crypt_table_string_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crypt_table_string_hash: one-way string hash over a crypt table
// Result: a hash is loaded into the output register when its terminating
//   zero byte leaves stage 1 (the seeds already hold the finished hash).
// Throughput: one byte per cycle while no terminator waits for the output; the seed feedback is one add, xor and sum.
// Reset: seeds return to their start values and the 1280-word table is
//   refilled; s_tready stays low until the fill is done, two generator
//   steps per word, while configuration writes are still taken.
// ----------------------------------------------------------------------------
module crypt_table_string_hash (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: hash_type register
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,   // hash_type
	// byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // [7:0] char_code
	// hash results out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata        // [31:0] hash_value
);
	import cths_pkg::*;

	cths_fill_t fill;

	logic [1:0]        hash_type_q;
	logic              s_accept;
	logic [7:0]        ch_in;
	logic [TBL_AW-1:0] rd_addr;
	logic [WORD_W-1:0] tbl_word;

	// stage 1: request whose table word is being read
	logic              valid_s1;
	logic              zero_s1;
	logic [7:0]        ch_s1;
	logic              adv_s1;

	logic [WORD_W-1:0] seed1_q;
	logic [WORD_W-1:0] seed2_q;
	logic [WORD_W-1:0] seed1_nx;
	logic [WORD_W-1:0] seed2_nx;

	logic              m_tvalid_q;
	logic [WORD_W-1:0] m_tdata_q;

	cths_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.fill   (fill)
	);

	// Fold the byte before the lookup; the row comes from hash_type.
	assign ch_in   = fold_upper(s_tdata);
	assign rd_addr = TBL_AW'({hash_type_q, ch_in});

	cths_ram #(
		.DATA_W (WORD_W),
		.DEPTH  (TBL_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (fill.we),
		.waddr (fill.addr),
		.wdata (fill.data),
		.re    (s_accept),
		.raddr (rd_addr),
		.rdata (tbl_word)
	);

	// A non-zero byte always retires; a terminator waits for a free output slot.
	assign adv_s1   = !zero_s1 || !m_tvalid_q || m_tready;
	assign s_tready = fill.done && (!valid_s1 || adv_s1);
	assign s_accept = s_tvalid && s_tready;

	// Configuration register: the user must write it only while idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_type_q <= 2'd0;
		end else if (cfg_wr_en) begin
			hash_type_q <= cfg_wr_data;
		end
	end

	// Advance stage 1 whenever its slot frees up; the table word follows
	// on the RAM's registered output, held by the read enable on a stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_s1) begin
			valid_s1 <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			ch_s1   <= ch_in;
			zero_s1 <= (s_tdata == 8'h00);
		end
	end

	// Seed update for one byte.
	always_comb begin
		seed1_nx = tbl_word ^ (seed1_q + seed2_q);
		seed2_nx = WORD_W'(ch_s1) + seed1_nx + seed2_q + (seed2_q << 5) + SEED2_ADD;
	end

	// Hold the seeds between names; drop back to the start values on a terminator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed1_q <= SEED1_INIT;
			seed2_q <= SEED2_INIT;
		end else if (valid_s1 && adv_s1) begin
			if (zero_s1) begin
				seed1_q <= SEED1_INIT;
				seed2_q <= SEED2_INIT;
			end else begin
				seed1_q <= seed1_nx;
				seed2_q <= seed2_nx;
			end
		end
	end

	// Output register: load the finished hash, clear once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (valid_s1 && zero_s1 && adv_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && zero_s1 && adv_s1) begin
			m_tdata_q <= seed1_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_no_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |-> (fill.done && !fill.we))
		else $error("request accepted while table fill runs");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(valid_s1 && zero_s1))
		else $error("result without a terminating byte");

	a_seed_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && zero_s1 && adv_s1) |=>
			(seed1_q == SEED1_INIT && seed2_q == SEED2_INIT))
		else $error("seeds not restarted after a terminator");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the crypt table string hash
// Streams names one byte per request into the hash block and compares every
// emitted hash against an in-bench model. The model builds the same crypt
// table at start and updates the seed pair per accepted byte. Names are
// mostly well formed, carry mixed case, punctuation and high bytes, and
// sometimes end a phase unterminated so that the hash type changes mid-name.
// Both sides idle in random bursts. One phase holds the result side off for
// a long stretch so that the block backs up its input.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          TBL_WORDS    = 1280;
	localparam int          TBL_COLS     = 256;
	localparam int          TBL_ROWS     = 5;
	localparam int unsigned LCG_START    = 32'h00100001;
	localparam int unsigned LCG_MOD      = 32'h002AAAAB;
	localparam int unsigned LCG_MULT     = 125;
	localparam int unsigned LCG_ADD      = 3;
	localparam logic [31:0] SEED_A_START = 32'h7FED7FED;
	localparam logic [31:0] SEED_B_START = 32'hEEEEEEEE;
	localparam logic [7:0]  NAME_END     = 8'h00;
	localparam int          DRAIN_CYCLES = 6;    // settling time after the last hash
	localparam int          PHASES       = 9;
	localparam int          PHASE_BYTES  = 140;
	localparam int          HOLD_PHASE   = 3;
	localparam int          PAUSE_PHASE  = 5;
	localparam int          HOLD_CYCLES  = 300;

	// Hash model: crypt table, seed pair and the queue of hashes still owed.
	class hash_scoreboard;
		logic [31:0] crypt_words [TBL_WORDS];
		logic [31:0] seed_a;
		logic [31:0] seed_b;
		logic [1:0]  row_sel;
		logic [31:0] owed_hashes [$];
		int          errors;

		function new();
			int unsigned g;
			logic [15:0] hi;
			g = LCG_START;
			for (int col = 0; col < TBL_COLS; col++) begin
				for (int row = 0; row < TBL_ROWS; row++) begin
					g  = (g * LCG_MULT + LCG_ADD) % LCG_MOD;
					hi = g[15:0];
					g  = (g * LCG_MULT + LCG_ADD) % LCG_MOD;
					crypt_words[row * TBL_COLS + col] = {hi, g[15:0]};
				end
			end
			seed_a  = SEED_A_START;
			seed_b  = SEED_B_START;
			row_sel = 2'd0;
			errors  = 0;
		endfunction

		function void note_byte(input logic [7:0] code);
			logic [7:0]  ch;
			logic [31:0] word;
			if (code == NAME_END) begin
				owed_hashes.push_back(seed_a);
				seed_a = SEED_A_START;
				seed_b = SEED_B_START;
				return;
			end
			ch     = (code >= 8'h61 && code <= 8'h7A) ? code - 8'h20 : code;
			word   = crypt_words[{row_sel, ch}];
			seed_a = word ^ (seed_a + seed_b);
			seed_b = {24'h0, ch} + seed_a + seed_b + (seed_b << 5) + 32'd3;
		endfunction

		function void check_hash(input logic [31:0] got);
			logic [31:0] want;
			if (owed_hashes.size() == 0) begin
				$error("hash_value: no result expected, actual %08h", got);
				errors++;
				return;
			end
			want = owed_hashes.pop_front();
			if (got !== want) begin
				$error("hash_value: expected %08h, actual %08h", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return owed_hashes.size();
		endfunction
	endclass

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [1:0]  cfg_wr_data = 2'd0;
	logic        s_tvalid    = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata     = 8'h00;   // [7:0] char_code
	logic        m_tvalid;
	logic        m_tready    = 1'b0;
	logic [31:0] m_tdata;               // [31:0] hash_value

	hash_scoreboard sb;
	logic quiet       = 1'b0;   // no idling on either side once set
	logic rx_hold     = 1'b0;   // long hold-off on the result side
	int   rx_idle_pct = 0;
	int   tx_idle_pct = 0;
	int   rx_gap      = 0;
	int   bytes_sent  = 0;

	crypt_table_string_hash i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: check each accepted hash, then pick the ready level for the
	// next cycle. Hold low for the whole long hold-off, otherwise idle in
	// random bursts.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sb.check_hash(m_tdata);
		end
		if (rx_hold) begin
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap = rx_gap - 1;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
			rx_gap = $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offer one byte and hold it until the block takes the request; then
	// maybe drop valid for an idle burst.
	task automatic send_byte(input logic [7:0] code);
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(code);
		bytes_sent++;
		if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Pick a name byte: mostly letters of both cases, plus digits, the
	// characters right around the letter ranges, and high bytes.
	function automatic logic [7:0] pick_char();
		logic [7:0] edges [8];
		edges = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h5C, 8'h2E, 8'h5F, 8'h7F};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				return 8'($urandom_range(8'h61, 8'h7A));
			end
			4, 5: begin
				return 8'($urandom_range(8'h41, 8'h5A));
			end
			6: begin
				return 8'($urandom_range(8'h30, 8'h39));
			end
			7: begin
				return edges[$urandom_range(0, 7)];
			end
			8: begin
				return 8'($urandom_range(8'h80, 8'hFF));
			end
			default: begin
				return 8'($urandom_range(1, 255));
			end
		endcase
	endfunction

	task automatic send_name(input int len, input bit terminate);
		for (int i = 0; i < len; i++) begin
			send_byte(pick_char());
		end
		if (terminate) begin
			send_byte(NAME_END);
		end
	endtask

	// Drop valid and wait until every owed hash has come out, then let the
	// pipeline settle so that a register write lands on an idle block.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_hash_type(input logic [1:0] t);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= t;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.row_sel = t;
		@(posedge clk);
	endtask

	task automatic hold_sink(input int cycles);
		rx_hold <= 1'b1;
		repeat (cycles) @(posedge clk);
		rx_hold <= 1'b0;
	endtask

	task automatic send_list(input logic [7:0] codes [$]);
		foreach (codes[i]) begin
			send_byte(codes[i]);
		end
	endtask

	initial begin
		int phase_start;
		int len;
		sb = new();

		// Hold reset, then release; the block fills its table before it takes
		// any byte.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Write the register while the table is still being filled.
		write_hash_type(2'd0);

		// Directed names: empty name, case fold on both sides of the letter
		// ranges, the byte extremes and high bytes left unfolded.
		tx_idle_pct = 20;
		rx_idle_pct <= 20;
		send_list('{NAME_END});
		send_list('{8'h61, NAME_END});
		send_list('{8'h41, NAME_END});
		send_list('{8'h7A, 8'h7B, 8'h60, NAME_END});
		send_list('{8'h40, 8'h5B, 8'h7F, NAME_END});
		send_list('{8'h80, 8'hFF, 8'h01, NAME_END});

		// Change the hash type in the middle of a name, and use row three.
		send_byte(8'h68);
		drain_results();
		write_hash_type(2'd3);
		send_list('{8'h69, 8'h5A, NAME_END});
		drain_results();

		// Random phases, each under its own hash type and idle mix.
		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) begin
				quiet <= 1'b1;
			end
			if (p < 4) begin
				write_hash_type(2'((p + 1) % 4));
			end else begin
				write_hash_type(2'($urandom_range(0, 3)));
			end
			tx_idle_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 40);
			rx_idle_pct <= (p % 4 == 1) ? 0 : $urandom_range(10, 40);

			// Hold the result side off while short names keep coming, so the
			// block backs up and stalls its input.
			if (p == HOLD_PHASE) begin
				fork
					hold_sink(HOLD_CYCLES);
				join_none
			end

			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				if (p == HOLD_PHASE && bytes_sent - phase_start < 60) begin
					len = $urandom_range(0, 2);
				end else if ($urandom_range(0, 19) == 0) begin
					len = $urandom_range(20, 40);
				end else begin
					len = $urandom_range(0, 12);
				end
				send_name(len, 1'b1);
				// Pause the sender once until every hash is out.
				if (p == PAUSE_PHASE && bytes_sent - phase_start >= PHASE_BYTES / 2 &&
				    bytes_sent - phase_start < PHASE_BYTES / 2 + len + 1) begin
					drain_results();
				end
			end

			// Leave a name open now and then; the next phase finishes it under
			// the hash type that it writes.
			if (p < PHASES - 1 && $urandom_range(0, 1) == 1) begin
				send_name($urandom_range(1, 4), 1'b0);
			end
			drain_results();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Guard against a hung handshake; this is far past the slowest run.
	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
design/cths_pkg.sv
design/cths_ram.sv
design/cths_fill.sv
design/crypt_table_string_hash.sv
sim/tb_top.sv
